// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, disabled while reset is high
`define CHECK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that is also checked during reset
`define CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/qelb_pkg.sv =====
// shared types and constants for the quad element local basis core
// no dependencies
package qelb_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int U_W         = 32;
  localparam int Q_FRAC      = 30;
  localparam int CR_W        = 2 * Q_FRAC + 2;
  localparam logic [U_W-1:0] ONE_Q30 = U_W'(1) << Q_FRAC;

  // three Q2.30 components, index 0 is x
  typedef logic [2:0][U_W-1:0] vec_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] n0_x;
    logic signed [COORD_WIDTH-1:0] n0_y;
    logic signed [COORD_WIDTH-1:0] n0_z;
    logic signed [COORD_WIDTH-1:0] n1_x;
    logic signed [COORD_WIDTH-1:0] n1_y;
    logic signed [COORD_WIDTH-1:0] n1_z;
    logic signed [COORD_WIDTH-1:0] n2_x;
    logic signed [COORD_WIDTH-1:0] n2_y;
    logic signed [COORD_WIDTH-1:0] n2_z;
    logic signed [COORD_WIDTH-1:0] n3_x;
    logic signed [COORD_WIDTH-1:0] n3_y;
    logic signed [COORD_WIDTH-1:0] n3_z;
  } in_t;

  typedef struct packed {
    logic signed [U_W-1:0] ex_x;
    logic signed [U_W-1:0] ex_y;
    logic signed [U_W-1:0] ex_z;
    logic signed [U_W-1:0] ey_x;
    logic signed [U_W-1:0] ey_y;
    logic signed [U_W-1:0] ey_z;
    logic signed [U_W-1:0] ez_x;
    logic signed [U_W-1:0] ez_y;
    logic signed [U_W-1:0] ez_z;
    logic                  degenerate;
  } out_t;

endpackage

// ===== rtl/quad_element_local_basis_core.sv =====
// Accepts one word per cycle unless a stalled result holds the pipeline.
// The datapath is fully pipelined: five normalizers (sqrt and
// divide at one bit per stage) and three cross product units.
// A stalled result freezes every stage; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// top level: diagonal differences, normal, helper axis, in-plane axes
// depends on qelb_pkg, qelb_norm, qelb_cross, assert_macros.svh
`include "assert_macros.svh"
module quad_element_local_basis_core import qelb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  in_t  item,
  output logic result_valid,
  input  logic result_stall,
  output out_t result
);

  localparam int EZ_SIDE = 1 + 3 * U_W;
  localparam int EY_SIDE = 1 + 6 * U_W;

  logic en;
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  // diagonal differences
  logic signed [COORD_WIDTH-1:0] p0 [3], p1 [3], p2 [3], p3 [3];
  logic signed [COORD_WIDTH:0]   e1 [3], e2 [3];

  assign p0[0] = item.n0_x; assign p0[1] = item.n0_y; assign p0[2] = item.n0_z;
  assign p1[0] = item.n1_x; assign p1[1] = item.n1_y; assign p1[2] = item.n1_z;
  assign p2[0] = item.n2_x; assign p2[1] = item.n2_y; assign p2[2] = item.n2_z;
  assign p3[0] = item.n3_x; assign p3[1] = item.n3_y; assign p3[2] = item.n3_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = {p1[k][COORD_WIDTH-1], p1[k]} - {p3[k][COORD_WIDTH-1], p3[k]};
      e2[k] = {p2[k][COORD_WIDTH-1], p2[k]} - {p0[k][COORD_WIDTH-1], p0[k]};
    end
  end

  logic                         d_valid;
  logic [2:0]                   dneg1, dneg2;
  logic [2:0][COORD_WIDTH-1:0]  dmag1, dmag2;

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (en) d_valid <= item_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dneg1[k] <= e1[k][COORD_WIDTH];
        dneg2[k] <= e2[k][COORD_WIDTH];
        dmag1[k] <= e1[k][COORD_WIDTH] ? COORD_WIDTH'(-e1[k]) : COORD_WIDTH'(e1[k]);
        dmag2[k] <= e2[k][COORD_WIDTH] ? COORD_WIDTH'(-e2[k]) : COORD_WIDTH'(e2[k]);
      end
    end
  end

  // unit diagonals, side carries the zero-difference flag
  logic nd1_valid, nd2_valid, nd1_nz, nd2_nz, nd1_side, nd2_side;
  vec_t nd1_u, nd2_u;

  qelb_norm #(.MAG_W(COORD_WIDTH), .SIDE_W(1)) u_norm_d1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid), .in_neg(dneg1), .in_mag(dmag1),
    .in_side(dmag1 == '0), .out_valid(nd1_valid), .out_u(nd1_u), .out_nz(nd1_nz),
    .out_side(nd1_side)
  );

  qelb_norm #(.MAG_W(COORD_WIDTH), .SIDE_W(1)) u_norm_d2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid), .in_neg(dneg2), .in_mag(dmag2),
    .in_side(dmag2 == '0), .out_valid(nd2_valid), .out_u(nd2_u), .out_nz(nd2_nz),
    .out_side(nd2_side)
  );

  // normal direction
  logic                c1_valid, c1_ok;
  logic [2:0]          c1_neg;
  logic [2:0][CR_W-1:0] c1_mag;

  qelb_cross #(.SIDE_W(1)) u_cross_n (
    .clk(clk), .rst(rst), .en(en), .in_valid(nd1_valid && nd2_valid), .a(nd1_u),
    .b(nd2_u), .in_side(nd1_nz && nd2_nz), .out_valid(c1_valid), .out_neg(c1_neg),
    .out_mag(c1_mag), .out_side(c1_ok)
  );

  logic nez_valid, nez_nz, nez_side;
  vec_t nez_u;

  qelb_norm #(.MAG_W(CR_W), .SIDE_W(1)) u_norm_ez (
    .clk(clk), .rst(rst), .en(en), .in_valid(c1_valid), .in_neg(c1_neg), .in_mag(c1_mag),
    .in_side(c1_ok), .out_valid(nez_valid), .out_u(nez_u), .out_nz(nez_nz),
    .out_side(nez_side)
  );

  // helper axis selection
  logic [U_W-1:0] ax, ay, az, big;
  axis_t          h;
  vec_t           hv;

  always_comb begin
    ax  = nez_u[0][U_W-1] ? (U_W'(0) - nez_u[0]) : nez_u[0];
    ay  = nez_u[1][U_W-1] ? (U_W'(0) - nez_u[1]) : nez_u[1];
    az  = nez_u[2][U_W-1] ? (U_W'(0) - nez_u[2]) : nez_u[2];
    h   = AXIS_X;
    big = az;
    if (ax > az) begin
      big = ax;
      h   = AXIS_Y;
    end
    if (ay > big) h = AXIS_Z;
    hv = '0;
    case (h)
      AXIS_X:  hv[0] = ONE_Q30;
      AXIS_Y:  hv[1] = ONE_Q30;
      AXIS_Z:  hv[2] = ONE_Q30;
      default: hv[0] = ONE_Q30;
    endcase
  end

  logic hs_valid, hs_ok;
  vec_t hs_ez, hs_hv;

  always_ff @(posedge clk) begin
    if (rst) hs_valid <= 1'b0;
    else if (en) hs_valid <= nez_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hs_ok <= nez_side && nez_nz;
      hs_ez <= nez_u;
      hs_hv <= hv;
    end
  end

  // local y axis
  logic                 c2_valid;
  logic [2:0]           c2_neg;
  logic [2:0][CR_W-1:0] c2_mag;
  logic [EZ_SIDE-1:0]   c2_side;

  qelb_cross #(.SIDE_W(EZ_SIDE)) u_cross_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(hs_valid), .a(hs_ez), .b(hs_hv),
    .in_side({hs_ok, hs_ez}), .out_valid(c2_valid), .out_neg(c2_neg), .out_mag(c2_mag),
    .out_side(c2_side)
  );

  logic               ney_valid, ney_nz;
  vec_t               ney_u;
  logic [EZ_SIDE-1:0] ney_side;

  qelb_norm #(.MAG_W(CR_W), .SIDE_W(EZ_SIDE)) u_norm_ey (
    .clk(clk), .rst(rst), .en(en), .in_valid(c2_valid), .in_neg(c2_neg), .in_mag(c2_mag),
    .in_side(c2_side), .out_valid(ney_valid), .out_u(ney_u), .out_nz(ney_nz),
    .out_side(ney_side)
  );

  // local x axis
  logic                 c3_valid;
  logic [2:0]           c3_neg;
  logic [2:0][CR_W-1:0] c3_mag;
  logic [EY_SIDE-1:0]   c3_side;
  vec_t                 ey_ez;

  assign ey_ez = ney_side[3*U_W-1:0];

  qelb_cross #(.SIDE_W(EY_SIDE)) u_cross_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(ney_valid), .a(ney_u), .b(ey_ez),
    .in_side({ney_side[EZ_SIDE-1] && ney_nz, ey_ez, ney_u}), .out_valid(c3_valid),
    .out_neg(c3_neg), .out_mag(c3_mag), .out_side(c3_side)
  );

  logic               nex_valid, nex_nz;
  vec_t               nex_u;
  logic [EY_SIDE-1:0] nex_side;

  qelb_norm #(.MAG_W(CR_W), .SIDE_W(EY_SIDE)) u_norm_ex (
    .clk(clk), .rst(rst), .en(en), .in_valid(c3_valid), .in_neg(c3_neg), .in_mag(c3_mag),
    .in_side(c3_side), .out_valid(nex_valid), .out_u(nex_u), .out_nz(nex_nz),
    .out_side(nex_side)
  );

  // output word register
  logic ok;
  vec_t fz, fy;

  assign ok = nex_side[EY_SIDE-1] && nex_nz;
  assign fz = nex_side[6*U_W-1:3*U_W];
  assign fy = nex_side[3*U_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (en) result_valid <= nex_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.ex_x       <= ok ? nex_u[0] : '0;
      result.ex_y       <= ok ? nex_u[1] : '0;
      result.ex_z       <= ok ? nex_u[2] : '0;
      result.ey_x       <= ok ? fy[0] : '0;
      result.ey_y       <= ok ? fy[1] : '0;
      result.ey_z       <= ok ? fy[2] : '0;
      result.ez_x       <= ok ? fz[0] : '0;
      result.ez_y       <= ok ? fz[1] : '0;
      result.ez_z       <= ok ? fz[2] : '0;
      result.degenerate <= !ok;
    end
  end

  // checks
  `CHECK_RST(a_lanes_aligned, clk, rst, nd1_valid == nd2_valid,
    "diagonal normalizer lanes out of step")
  `CHECK_RST(a_zero_detect, clk, rst, nd1_valid |-> (nd1_nz != nd1_side),
    "normalizer zero flag disagrees with difference stage")
  `CHECK_RST(a_degenerate_zero, clk, rst,
    (result_valid && result.degenerate) |-> (result.ez_x == 0 && result.ez_y == 0 &&
    result.ez_z == 0 && result.ex_x == 0 && result.ey_y == 0),
    "degenerate word carries nonzero vectors")
  `CHECK_RST(a_stall_freeze, clk, rst,
    (result_valid && result_stall) |=> $stable(nex_valid) && $stable(hs_valid),
    "pipeline moved during a stall")

endmodule

// ===== rtl/qelb_cross.sv =====
// pipelined cross product of two Q2.30 vectors, sign/magnitude result
// depends on qelb_pkg
module qelb_cross import qelb_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  vec_t              a,
  input  vec_t              b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [2:0]        out_neg,
  output logic [2:0][CR_W-1:0] out_mag,
  output logic [SIDE_W-1:0] out_side
);

  logic signed [2*U_W-1:0] prod [6];
  logic signed [2*U_W-1:0] diff [3];
  logic              p_valid;
  logic [SIDE_W-1:0] p_side;

  // stage 1: six products
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= $signed(a[1]) * $signed(b[2]);
      prod[1] <= $signed(a[2]) * $signed(b[1]);
      prod[2] <= $signed(a[2]) * $signed(b[0]);
      prod[3] <= $signed(a[0]) * $signed(b[2]);
      prod[4] <= $signed(a[0]) * $signed(b[1]);
      prod[5] <= $signed(a[1]) * $signed(b[0]);
      p_side  <= in_side;
    end
  end

  // differences of product pairs
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = prod[2*k] - prod[2*k+1];
    end
  end

  // stage 2: sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        out_neg[k] <= diff[k][2*U_W-1];
        out_mag[k] <= diff[k][2*U_W-1] ? CR_W'(-diff[k]) : CR_W'(diff[k]);
      end
      out_side <= p_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
  end

endmodule

// ===== rtl/qelb_norm.sv =====
// pipelined vector normalizer: shift to range, sum of squares, root, divide
// depends on qelb_pkg
module qelb_norm import qelb_pkg::*; #(
  parameter int MAG_W  = CR_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2:0]        in_neg,
  input  logic [2:0][MAG_W-1:0] in_mag,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output vec_t              out_u,
  output logic              out_nz,
  output logic [SIDE_W-1:0] out_side
);

  localparam int S_W   = Q_FRAC;
  localparam int N     = (MAG_W > S_W) ? MAG_W : S_W;
  localparam int K     = $clog2(N);
  localparam int SUM_W = 2 * S_W + 2;
  localparam int RT_W  = SUM_W + 2;
  localparam int SQ    = SUM_W / 2 + 1;
  localparam int Q_W   = S_W + 1;
  localparam int REM_W = SUM_W;
  localparam int T     = K + SQ + Q_W + 5;

  // per-stage control and sideband
  logic              v    [0:T-1];
  logic [2:0]        negm [0:T-1];
  logic              zm   [0:T-1];
  logic [SIDE_W-1:0] sd   [0:T-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < T; t++) v[t] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
      for (int t = 1; t < T; t++) v[t] <= v[t-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negm[0] <= in_neg;
      zm[0]   <= (in_mag == '0);
      sd[0]   <= in_side;
      for (int t = 1; t < T; t++) begin
        negm[t] <= negm[t-1];
        zm[t]   <= zm[t-1];
        sd[t]   <= sd[t-1];
      end
    end
  end

  // input register and leading-zero shift steps
  logic [2:0][N-1:0] cm [0:K];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) cm[0][k] <= N'(in_mag[k]);
    end
  end

  for (genvar j = 1; j <= K; j++) begin : g_clz
    localparam int SH = 1 << (K - j);
    logic [N-1:0] orv;
    assign orv = cm[j-1][0] | cm[j-1][1] | cm[j-1][2];
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          cm[j][k] <= (orv[N-1 -: SH] == '0) ? (cm[j-1][k] << SH) : cm[j-1][k];
        end
      end
    end
  end

  // scaled components and their squares
  logic [2:0][S_W-1:0]   stop;
  logic [2:0][S_W-1:0]   sl [0:SQ+1];
  logic [2:0][2*S_W-1:0] sq;
  logic [SUM_W-1:0]      ssum;

  always_comb begin
    for (int k = 0; k < 3; k++) stop[k] = cm[K][k][N-1 -: S_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) sq[k] <= (2*S_W)'(stop[k]) * (2*S_W)'(stop[k]);
      sl[0] <= stop;
      ssum  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      for (int t = 1; t <= SQ + 1; t++) sl[t] <= sl[t-1];
    end
  end

  // integer square root, one result bit per stage
  logic [RT_W-1:0] rm [0:SQ-1];
  logic [RT_W-1:0] rt [0:SQ-1];

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (SQ - 1 - j));
    logic [RT_W-1:0] s_in, r_in, trial;
    if (j == 0) begin : g_first
      assign s_in = RT_W'(ssum);
      assign r_in = '0;
    end else begin : g_next
      assign s_in = rm[j-1];
      assign r_in = rt[j-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (s_in >= trial) begin
          rm[j] <= s_in - trial;
          rt[j] <= (r_in >> 1) + BIT;
        end else begin
          rm[j] <= s_in;
          rt[j] <= r_in >> 1;
        end
      end
    end
  end

  // rounded division by the length, one quotient bit per stage
  logic [Q_W-1:0]            lq [0:Q_W];
  logic [2:0][REM_W-1:0]     dv [0:Q_W];
  logic [2:0][Q_W-1:0]       qv [0:Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      lq[0] <= Q_W'(rt[SQ-1]);
      for (int k = 0; k < 3; k++) begin
        dv[0][k] <= REM_W'({sl[SQ+1][k], S_W'(0)}) + REM_W'(rt[SQ-1] >> 1);
        qv[0][k] <= '0;
      end
    end
  end

  for (genvar d = 1; d <= Q_W; d++) begin : g_div
    localparam int B = Q_W - d;
    logic [REM_W-1:0] tr;
    assign tr = REM_W'(lq[d-1]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        lq[d] <= lq[d-1];
        for (int k = 0; k < 3; k++) begin
          if (dv[d-1][k] >= tr) begin
            dv[d][k] <= dv[d-1][k] - tr;
            qv[d][k] <= qv[d-1][k] | (Q_W'(1) << B);
          end else begin
            dv[d][k] <= dv[d-1][k];
            qv[d][k] <= qv[d-1][k];
          end
        end
      end
    end
  end

  // signed result, zero for a zero-length vector
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (zm[T-2]) out_u[k] <= '0;
        else if (negm[T-2][k]) out_u[k] <= U_W'(0) - U_W'(qv[Q_W][k]);
        else out_u[k] <= U_W'(qv[Q_W][k]);
      end
    end
  end

  assign out_valid = v[T-1];
  assign out_nz    = !zm[T-1];
  assign out_side  = sd[T-1];

endmodule
